// ===== design/priority_intent_arbiter_top_defines.svh =====
// assertion macros for the priority intent arbiter checker
// needs signals named clock and reset in the scope of each use
`ifndef PRIORITY_INTENT_ARBITER_TOP_DEFINES_SVH
`define PRIORITY_INTENT_ARBITER_TOP_DEFINES_SVH

// same-cycle implication
`define PIA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pia check failed");

// next-cycle implication
`define PIA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pia check failed");

`endif

// ===== design/pia_pkg.sv =====
// shared types and constants of the priority intent arbiter
// no dependencies
`default_nettype none

package pia_pkg;

   localparam logic [1:0] MODE_SUBMIT  = 2'd0;
   localparam logic [1:0] MODE_RESOLVE = 2'd1;
   localparam logic [1:0] MODE_REMOVE  = 2'd2;
   localparam logic [1:0] MODE_CLEAR   = 2'd3;

   localparam logic [7:0] STALE_WINDOW_RESET = 8'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic read;
      logic eval;
      logic commit;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ===== design/pia_ctrl.sv =====
// controller state machine of the priority intent arbiter
// depends on pia_pkg
`default_nettype none

module pia_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   output logic              csr_ready,
   output logic              rsp_strobe,
   output pia_pkg::dp_cmd_type cmd
);
   import pia_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_EVAL  = 4'b0100,
      S_WRITE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) state_in = S_READ;
         S_READ:  state_in = S_EVAL;
         S_EVAL:  state_in = S_WRITE;
         S_WRITE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_strobe = (state_ff == S_WRITE);

   always_comb begin
      cmd.load   = (state_ff == S_IDLE) && start;
      cmd.read   = (state_ff == S_READ);
      cmd.eval   = (state_ff == S_EVAL);
      cmd.commit = (state_ff == S_WRITE);
   end

endmodule

`default_nettype wire

// ===== design/pia_dpath.sv =====
// datapath of the priority intent arbiter: slot row memories, valid bits,
// row evaluation and result registers; depends on pia_pkg
`default_nettype none

module pia_dpath #(
   parameter int NUM_OBJECTS      = 16,
   parameter int SLOTS_PER_OBJECT = 8,
   parameter int PAYLOAD_BITS     = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  pia_pkg::dp_cmd_type cmd,
   input  wire  [1:0]          req_mode,
   input  wire  [3:0]          req_object_id,
   input  wire                 req_object_valid,
   input  wire  [15:0]         req_source_id,
   input  wire  signed [15:0]  req_priority_req,
   input  wire  [31:0]         req_intent_payload,
   input  wire                 req_jump_pressed,
   input  wire  [31:0]         req_frame_index,
   input  wire                 csr_write,
   input  wire  [7:0]          csr_stale_window,
   output logic                rsp_found,
   output logic [31:0]         rsp_out_payload,
   output logic                rsp_out_jump,
   output logic [15:0]         rsp_out_source,
   output logic                rsp_overflow
);
   import pia_pkg::*;

   localparam int OBJ_W  = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
   localparam int SLOT_W = (SLOTS_PER_OBJECT > 1) ? $clog2(SLOTS_PER_OBJECT) : 1;
   localparam int NS     = SLOTS_PER_OBJECT;

   // request registers
   logic [1:0]              mode_ff;
   logic [OBJ_W-1:0]        obj_ff;
   logic                    ok_ff;
   logic [15:0]             src_ff;
   logic [15:0]             pri_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic                    jmp_ff;
   logic [31:0]             frame_ff;
   logic [7:0]              stale_ff;

   // slot row memories
   logic [NS-1:0][15:0]             mem_src [NUM_OBJECTS];
   logic [NS-1:0][15:0]             mem_pri [NUM_OBJECTS];
   logic [NS-1:0][31:0]             mem_frm [NUM_OBJECTS];
   logic [NS-1:0][PAYLOAD_BITS-1:0] mem_pay [NUM_OBJECTS];
   logic [NS-1:0]                   mem_jmp [NUM_OBJECTS];
   logic [NS-1:0]                   valid_ff [NUM_OBJECTS];

   // row read registers
   logic [NS-1:0][15:0]             rd_src_ff, rd_pri_ff;
   logic [NS-1:0][31:0]             rd_frm_ff;
   logic [NS-1:0][PAYLOAD_BITS-1:0] rd_pay_ff;
   logic [NS-1:0]                   rd_jmp_ff, rd_vld_ff;

   // write-back registers
   logic [NS-1:0][15:0]             wr_src_ff, wr_pri_ff, wr_src_in, wr_pri_in;
   logic [NS-1:0][31:0]             wr_frm_ff, wr_frm_in;
   logic [NS-1:0][PAYLOAD_BITS-1:0] wr_pay_ff, wr_pay_in;
   logic [NS-1:0]                   wr_jmp_ff, wr_jmp_in, wr_vld_ff, wr_vld_in;
   logic row_we_ff, row_we_in, vld_we_ff, vld_we_in, clr_ff, clr_in;

   // result registers
   logic        found_ff, found_in, jump_ff, jump_in, ovf_ff, ovf_in;
   logic [31:0] payload_ff, payload_in;
   logic [15:0] source_ff, source_in;

   logic [31:0] obj_ext;
   logic [63:0] pay_ext;

   assign obj_ext = 32'(req_object_id);
   assign pay_ext = 64'(req_intent_payload);

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ff <= STALE_WINDOW_RESET;
      end else if (csr_write) begin
         stale_ff <= csr_stale_window;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         obj_ff   <= obj_ext[OBJ_W-1:0];
         ok_ff    <= req_object_valid && (obj_ext < 32'(NUM_OBJECTS));
         src_ff   <= req_source_id;
         pri_ff   <= req_priority_req;
         pay_ff   <= pay_ext[PAYLOAD_BITS-1:0];
         jmp_ff   <= req_jump_pressed;
         frame_ff <= req_frame_index;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_src_ff <= mem_src[obj_ff];
         rd_pri_ff <= mem_pri[obj_ff];
         rd_frm_ff <= mem_frm[obj_ff];
         rd_pay_ff <= mem_pay[obj_ff];
         rd_jmp_ff <= mem_jmp[obj_ff];
      end
      if (cmd.commit && row_we_ff) begin
         mem_src[obj_ff] <= wr_src_ff;
         mem_pri[obj_ff] <= wr_pri_ff;
         mem_frm[obj_ff] <= wr_frm_ff;
         mem_pay[obj_ff] <= wr_pay_ff;
         mem_jmp[obj_ff] <= wr_jmp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_OBJECTS; i++) valid_ff[i] <= '0;
         rd_vld_ff <= '0;
      end else begin
         if (cmd.read) rd_vld_ff <= valid_ff[obj_ff];
         if (cmd.commit) begin
            if (clr_ff) begin
               for (int i = 0; i < NUM_OBJECTS; i++) valid_ff[i] <= '0;
            end else if (vld_we_ff) begin
               valid_ff[obj_ff] <= wr_vld_ff;
            end
         end
      end
   end

   // row evaluation
   logic              hit_found, free_found, win_found;
   logic [SLOT_W-1:0] hit_idx, free_idx, sel_idx, win_idx;
   logic [15:0]       best_pri, best_src;
   logic [63:0]       win_pay;

   always_comb begin
      hit_found = 1'b0; hit_idx = '0;
      free_found = 1'b0; free_idx = '0;
      win_found = 1'b0; win_idx = '0;
      best_pri = '0; best_src = '0;
      for (int i = 0; i < NS; i++) begin
         if (rd_vld_ff[i] && rd_src_ff[i] == src_ff && !hit_found) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(i);
         end
         if (!rd_vld_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
         if (rd_vld_ff[i] && rd_frm_ff[i] == frame_ff) begin
            if (!win_found || $signed(rd_pri_ff[i]) > $signed(best_pri) ||
                (rd_pri_ff[i] == best_pri && rd_src_ff[i] < best_src)) begin
               win_found = 1'b1;
               win_idx   = SLOT_W'(i);
               best_pri  = rd_pri_ff[i];
               best_src  = rd_src_ff[i];
            end
         end
      end
      sel_idx = hit_found ? hit_idx : free_idx;
      win_pay = 64'(rd_pay_ff[win_idx]);
   end

   always_comb begin
      wr_src_in = rd_src_ff;
      wr_pri_in = rd_pri_ff;
      wr_frm_in = rd_frm_ff;
      wr_pay_in = rd_pay_ff;
      wr_jmp_in = rd_jmp_ff;
      wr_vld_in = rd_vld_ff;
      row_we_in = 1'b0; vld_we_in = 1'b0; clr_in = 1'b0;
      found_in = 1'b0; jump_in = 1'b0; ovf_in = 1'b0;
      payload_in = '0; source_in = '0;
      case (mode_ff)
         MODE_SUBMIT: begin
            if (ok_ff && src_ff != 16'd0) begin
               if (hit_found || free_found) begin
                  wr_src_in[sel_idx] = src_ff;
                  wr_pri_in[sel_idx] = pri_ff;
                  wr_frm_in[sel_idx] = frame_ff;
                  wr_pay_in[sel_idx] = pay_ff;
                  wr_jmp_in[sel_idx] = (hit_found && rd_jmp_ff[sel_idx]) || jmp_ff;
                  wr_vld_in[sel_idx] = 1'b1;
                  // drop stale slots whose latch is clear
                  for (int i = 0; i < NS; i++) begin
                     if (wr_vld_in[i] && !wr_jmp_in[i] &&
                         ({1'b0, frame_ff} > ({1'b0, wr_frm_in[i]} + 33'(stale_ff))))
                        wr_vld_in[i] = 1'b0;
                  end
                  row_we_in = 1'b1;
                  vld_we_in = 1'b1;
                  found_in  = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         MODE_RESOLVE: begin
            if (ok_ff && win_found) begin
               found_in   = 1'b1;
               payload_in = win_pay[31:0];
               jump_in    = rd_jmp_ff[win_idx];
               source_in  = best_src;
               wr_jmp_in[win_idx] = 1'b0;
               row_we_in  = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (ok_ff) begin
               wr_vld_in = '0;
               vld_we_in = 1'b1;
            end
         end
         MODE_CLEAR: clr_in = 1'b1;
         default: clr_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         wr_src_ff  <= wr_src_in;
         wr_pri_ff  <= wr_pri_in;
         wr_frm_ff  <= wr_frm_in;
         wr_pay_ff  <= wr_pay_in;
         wr_jmp_ff  <= wr_jmp_in;
         wr_vld_ff  <= wr_vld_in;
         found_ff   <= found_in;
         jump_ff    <= jump_in;
         ovf_ff     <= ovf_in;
         payload_ff <= payload_in;
         source_ff  <= source_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_we_ff <= 1'b0;
         vld_we_ff <= 1'b0;
         clr_ff    <= 1'b0;
      end else if (cmd.eval) begin
         row_we_ff <= row_we_in;
         vld_we_ff <= vld_we_in;
         clr_ff    <= clr_in;
      end
   end

   assign rsp_found       = found_ff;
   assign rsp_out_payload = payload_ff;
   assign rsp_out_jump    = jump_ff;
   assign rsp_out_source  = source_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

`default_nettype wire

// ===== design/priority_intent_arbiter_top.sv =====
// top level of the priority intent arbiter
// instantiates pia_ctrl and pia_dpath, depends on pia_pkg
`default_nettype none

// each command goes from the start transfer to the response in steps: it
// registers the command, reads the object's slot row from the row memories,
// compares all slots of the row in parallel, and writes the row back while
// the response is shown; busy is high for read, compare and write-back, so
// a new command starts only after the previous response. rsp_strobe marks
// the response for exactly one cycle and the receiver cannot stall it. the
// stale window register is written through csr_ only while the block is idle

module priority_intent_arbiter_top #(
   parameter int NUM_OBJECTS      = 16,
   parameter int SLOTS_PER_OBJECT = 8,
   parameter int PAYLOAD_BITS     = 32
) (
   input  wire                clock,
   input  wire                reset,
   // command transfer
   input  wire                start,
   output logic               busy,
   input  wire  [1:0]         req_mode,
   input  wire  [3:0]         req_object_id,
   input  wire                req_object_valid,
   input  wire  [15:0]        req_source_id,
   input  wire  signed [15:0] req_priority_req,
   input  wire  [31:0]        req_intent_payload,
   input  wire                req_jump_pressed,
   input  wire  [31:0]        req_frame_index,
   // response transfer
   output logic               rsp_strobe,
   output logic               rsp_found,
   output logic [31:0]        rsp_out_payload,
   output logic               rsp_out_jump,
   output logic [15:0]        rsp_out_source,
   output logic               rsp_overflow,
   // stale window register
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [7:0]         csr_stale_window
);
   import pia_pkg::*;

   dp_cmd_type cmd;

   // sequencing of each command
   pia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .csr_ready  (csr_ready),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // slot storage, evaluation and response registers
   pia_dpath #(
      .NUM_OBJECTS      (NUM_OBJECTS),
      .SLOTS_PER_OBJECT (SLOTS_PER_OBJECT),
      .PAYLOAD_BITS     (PAYLOAD_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_mode),
      .req_object_id      (req_object_id),
      .req_object_valid   (req_object_valid),
      .req_source_id      (req_source_id),
      .req_priority_req   (req_priority_req),
      .req_intent_payload (req_intent_payload),
      .req_jump_pressed   (req_jump_pressed),
      .req_frame_index    (req_frame_index),
      .csr_write          (csr_valid && csr_ready),
      .csr_stale_window   (csr_stale_window),
      .rsp_found          (rsp_found),
      .rsp_out_payload    (rsp_out_payload),
      .rsp_out_jump       (rsp_out_jump),
      .rsp_out_source     (rsp_out_source),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

`default_nettype wire

// ===== design/pia_checker.sv =====
// port-level checks of the priority intent arbiter, bound to the top level
// uses priority_intent_arbiter_top_defines.svh
`default_nettype none

`include "priority_intent_arbiter_top_defines.svh"

module pia_checker (
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        rsp_strobe,
   input wire        rsp_found,
   input wire [31:0] rsp_out_payload,
   input wire        rsp_out_jump,
   input wire [15:0] rsp_out_source,
   input wire        rsp_overflow
);

   `PIA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
   `PIA_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe && !busy)
   `PIA_ASSERT_IMPL(a_ovf_not_found, rsp_strobe && rsp_overflow, !rsp_found)
   `PIA_ASSERT_IMPL(a_miss_zero, rsp_strobe && !rsp_found,
                    rsp_out_payload == 32'd0 && rsp_out_source == 16'd0 && !rsp_out_jump)

endmodule

bind priority_intent_arbiter_top pia_checker u_pia_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_priority_intent_arbiter_top.sv =====
// self-checking testbench for priority_intent_arbiter_top
// depends on pia_pkg and the arbiter rtl; predicts each response from its own slot table
`timescale 1ns / 100ps

module tb_priority_intent_arbiter_top;
   import pia_pkg::*;

   localparam int N_OBJ = 16;
   localparam int N_SLOT = 8;
   localparam int TOTAL = N_OBJ * N_SLOT;

   typedef struct {
      logic [1:0]  mode;
      logic [3:0]  object_id;
      logic        object_valid;
      logic [15:0] source_id;
      logic [15:0] priority_req;
      logic [31:0] intent_payload;
      logic        jump_pressed;
      logic [31:0] frame_index;
   } command_type;

   typedef struct {
      logic        found;
      logic [31:0] payload;
      logic        jump;
      logic [15:0] source;
      logic        overflow;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_mode = '0;
   logic [3:0] req_object_id = '0;
   logic req_object_valid = 1'b0;
   logic [15:0] req_source_id = '0;
   logic signed [15:0] req_priority_req = '0;
   logic [31:0] req_intent_payload = '0;
   logic req_jump_pressed = 1'b0;
   logic [31:0] req_frame_index = '0;
   logic rsp_strobe, rsp_found, rsp_out_jump, rsp_overflow;
   logic [31:0] rsp_out_payload;
   logic [15:0] rsp_out_source;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_stale_window = '0;

   priority_intent_arbiter_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_object_id(req_object_id),
      .req_object_valid(req_object_valid), .req_source_id(req_source_id),
      .req_priority_req(req_priority_req), .req_intent_payload(req_intent_payload),
      .req_jump_pressed(req_jump_pressed), .req_frame_index(req_frame_index),
      .rsp_strobe(rsp_strobe), .rsp_found(rsp_found), .rsp_out_payload(rsp_out_payload),
      .rsp_out_jump(rsp_out_jump), .rsp_out_source(rsp_out_source),
      .rsp_overflow(rsp_overflow), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_stale_window(csr_stale_window)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state: the arbiter's slot table and window register
   logic [7:0]         window_q;
   logic               tab_valid [TOTAL];
   logic [15:0]        tab_source [TOTAL];
   logic signed [15:0] tab_prio [TOTAL];
   logic [31:0]        tab_frame [TOTAL];
   logic [31:0]        tab_payload [TOTAL];
   logic               tab_latch [TOTAL];

   command_type  pending_cmds [$];
   response_type expected_rsps [$];
   command_type  sent_cmd;
   logic busy_at_edge = 1'b0;
   int mismatches = 0;
   int sender_idle_pct = 0;

   task automatic queue_cmd(command_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // work out the response of one command and update the table
   function automatic response_type arbitrate(command_type c);
      response_type r;
      int base, hit, fre, sel;
      r = '{default: '0};
      base = c.object_id * N_SLOT;
      hit = -1; fre = -1; sel = -1;
      if (c.mode == MODE_CLEAR) begin
         for (int k = 0; k < TOTAL; k++) tab_valid[k] = 1'b0;
         return r;
      end
      if (!c.object_valid) return r;
      case (c.mode)
         MODE_SUBMIT: begin
            if (c.source_id == 16'd0) return r;
            for (int i = 0; i < N_SLOT; i++) begin
               if (tab_valid[base+i] && tab_source[base+i] == c.source_id && hit < 0)
                  hit = base + i;
               if (!tab_valid[base+i] && fre < 0) fre = base + i;
            end
            if (hit < 0) begin
               if (fre < 0) begin
                  r.overflow = 1'b1;
                  return r;
               end
               hit = fre;
               tab_valid[hit] = 1'b1;
               tab_source[hit] = c.source_id;
               tab_latch[hit] = 1'b0;
            end
            tab_prio[hit] = c.priority_req;
            tab_frame[hit] = c.frame_index;
            tab_payload[hit] = c.intent_payload;
            tab_latch[hit] = tab_latch[hit] | c.jump_pressed;
            // stale purge, compared at 33 bits so the sum never wraps
            for (int i = 0; i < N_SLOT; i++)
               if (tab_valid[base+i] && !tab_latch[base+i] &&
                   {1'b0, c.frame_index} > {1'b0, tab_frame[base+i]} + {25'd0, window_q})
                  tab_valid[base+i] = 1'b0;
            r.found = 1'b1;
         end
         MODE_RESOLVE: begin
            for (int i = 0; i < N_SLOT; i++) begin
               if (!tab_valid[base+i] || tab_frame[base+i] != c.frame_index) continue;
               if (sel < 0 || tab_prio[base+i] > tab_prio[sel] ||
                   (tab_prio[base+i] == tab_prio[sel] && tab_source[base+i] < tab_source[sel]))
                  sel = base + i;
            end
            if (sel >= 0) begin
               r.found = 1'b1;
               r.payload = tab_payload[sel];
               r.jump = tab_latch[sel];
               r.source = tab_source[sel];
               tab_latch[sel] = 1'b0;
            end
         end
         default: for (int i = 0; i < N_SLOT; i++) tab_valid[base+i] = 1'b0;
      endcase
      return r;
   endfunction

   task automatic drive_next();
      command_type c;
      c = pending_cmds.pop_front();
      sent_cmd = c;
      start <= 1'b1;
      req_mode <= c.mode;
      req_object_id <= c.object_id;
      req_object_valid <= c.object_valid;
      req_source_id <= c.source_id;
      req_priority_req <= c.priority_req;
      req_intent_payload <= c.intent_payload;
      req_jump_pressed <= c.jump_pressed;
      req_frame_index <= c.frame_index;
   endtask

   // driver: changes on the falling edge, holds start until the transfer is taken
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy_at_edge) begin
            // previous transfer taken at the last rising edge
            if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct)
               drive_next();
            else
               start <= 1'b0;
         end else if (!start && pending_cmds.size() > 0 &&
                      $urandom_range(99, 0) >= sender_idle_pct) begin
            drive_next();
         end
      end
   end

   always @(posedge clock) begin
      busy_at_edge <= busy;
      if (!reset && start && !busy)
         expected_rsps.insert(expected_rsps.size(), arbitrate(sent_cmd));
   end

   // monitor: each strobe is one response transfer
   always @(posedge clock) begin
      response_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transfer");
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_found !== e.found || rsp_out_payload !== e.payload ||
                rsp_out_jump !== e.jump || rsp_out_source !== e.source ||
                rsp_overflow !== e.overflow) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp found %0d pl %h j %0d src %h ovf %0d, ",
                            "got %0d %h %0d %h %0d"},
                           e.found, e.payload, e.jump, e.source, e.overflow, rsp_found,
                           rsp_out_payload, rsp_out_jump, rsp_out_source, rsp_overflow);
            end
         end
      end
   end

   function automatic command_type mk(logic [1:0] m, logic [3:0] o, logic v, logic [15:0] s,
                                      logic [15:0] p, logic [31:0] pl, logic j,
                                      logic [31:0] f);
      command_type c;
      c.mode = m; c.object_id = o; c.object_valid = v; c.source_id = s;
      c.priority_req = p; c.intent_payload = pl; c.jump_pressed = j; c.frame_index = f;
      return c;
   endfunction

   // wait until all queued commands have been answered and the block is quiet
   task automatic drain();
      while (pending_cmds.size() > 0 || start || expected_rsps.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_window(logic [7:0] w);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_stale_window <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      window_q = w;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random frame-structured traffic on a few objects so rows fill and resolve
   task automatic random_phase(int n, logic [31:0] frame0);
      logic [31:0] fr;
      int r;
      fr = frame0;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99, 0);
         if (r < 8) fr = fr + $urandom_range(4, 1);
         if (r < 55)
            queue_cmd(mk(MODE_SUBMIT, 4'($urandom_range(3, 0)),
               $urandom_range(15, 0) != 0,
               ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(12, 0)),
               ($urandom_range(1, 0) != 0) ? 16'($urandom) : 16'($urandom_range(3, 0)),
               $urandom, 1'($urandom_range(1, 0)), fr));
         else if (r < 88)
            queue_cmd(mk(MODE_RESOLVE, 4'($urandom_range(3, 0)),
               $urandom_range(15, 0) != 0,
               16'($urandom), 16'($urandom), $urandom, 1'($urandom_range(1, 0)),
               ($urandom_range(7, 0) == 0) ? $urandom : fr));
         else if (r < 96)
            queue_cmd(mk(MODE_REMOVE, 4'($urandom), 1'($urandom_range(1, 0)),
               16'($urandom), 16'($urandom), $urandom, 1'($urandom_range(1, 0)), $urandom));
         else
            queue_cmd(mk(MODE_CLEAR, 4'($urandom), 1'($urandom_range(1, 0)),
               16'($urandom), 16'($urandom), $urandom, 1'($urandom_range(1, 0)), $urandom));
      end
   endtask

   initial begin
      window_q = STALE_WINDOW_RESET;
      for (int k = 0; k < TOTAL; k++) begin
         tab_valid[k] = 1'b0; tab_source[k] = '0; tab_prio[k] = '0;
         tab_frame[k] = '0; tab_payload[k] = '0; tab_latch[k] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: invalid handle, source zero, ties, extremes, full row, latch, remove, clear
      queue_cmd(mk(MODE_SUBMIT, 4'd1, 1'b0, 16'd5, 16'd1, 32'h1, 1'b0, 32'd10));
      queue_cmd(mk(MODE_SUBMIT, 4'd1, 1'b1, 16'd0, 16'd1, 32'h1, 1'b0, 32'd10));
      queue_cmd(mk(MODE_SUBMIT, 4'd15, 1'b1, 16'hffff, 16'h7fff, 32'hffffffff,
                   1'b1, 32'hffffffff));
      queue_cmd(mk(MODE_SUBMIT, 4'd15, 1'b1, 16'h0001, 16'h7fff, 32'h0, 1'b0,
                   32'hffffffff));
      queue_cmd(mk(MODE_RESOLVE, 4'd15, 1'b1, 16'd0, 16'd0, 32'd0, 1'b0, 32'hffffffff));
      queue_cmd(mk(MODE_RESOLVE, 4'd15, 1'b1, 16'd0, 16'd0, 32'd0, 1'b0, 32'hffffffff));
      for (int s = 1; s <= 9; s++)
         queue_cmd(mk(MODE_SUBMIT, 4'd0, 1'b1, 16'(s), 16'h8000, 32'(s * 3),
                      s[0], 32'd0));
      queue_cmd(mk(MODE_RESOLVE, 4'd0, 1'b1, 16'd0, 16'd0, 32'd0, 1'b0, 32'd0));
      queue_cmd(mk(MODE_SUBMIT, 4'd0, 1'b1, 16'd2, 16'd0, 32'hdead, 1'b0, 32'd9));
      queue_cmd(mk(MODE_RESOLVE, 4'd0, 1'b0, 16'd0, 16'd0, 32'd0, 1'b0, 32'd9));
      queue_cmd(mk(MODE_RESOLVE, 4'd0, 1'b1, 16'd0, 16'd0, 32'd0, 1'b0, 32'd9));
      queue_cmd(mk(MODE_REMOVE, 4'd15, 1'b1, 16'd0, 16'd0, 32'd0, 1'b0, 32'd0));
      queue_cmd(mk(MODE_RESOLVE, 4'd15, 1'b1, 16'd0, 16'd0, 32'd0, 1'b0, 32'hffffffff));
      queue_cmd(mk(MODE_CLEAR, 4'd0, 1'b0, 16'd0, 16'd0, 32'd0, 1'b0, 32'd0));
      queue_cmd(mk(MODE_RESOLVE, 4'd0, 1'b1, 16'd0, 16'd0, 32'd0, 1'b0, 32'd0));
      drain();

      // random phases: window settings incl. extremes, sender idling varied
      write_window(8'd0);
      sender_idle_pct = 0;
      random_phase(140, 32'd100);
      drain();
      write_window(8'd255);
      sender_idle_pct = 65;
      random_phase(140, 32'hfffffff0);
      drain();
      write_window(8'd3);
      sender_idle_pct = 8;
      random_phase(140, $urandom);
      drain();
      write_window(8'($urandom));
      sender_idle_pct = 30;
      random_phase(130, 32'd0);
      drain();

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/pia_pkg.sv
design/pia_ctrl.sv
design/pia_dpath.sv
design/priority_intent_arbiter_top.sv
design/pia_checker.sv
tb/sv/tb_priority_intent_arbiter_top.sv
